@@ design/pem_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pem_pkg
// shared types and constants of the prewitt edge magnitude block
// ----------------------------------------------------------------------------
package pem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int SIZE_W     = 11;
    localparam int SUM_W      = 10;
    localparam int GRAD_W     = 13;
    localparam int MAG_W      = 24;
    localparam int ROOT_W     = 12;
    localparam int ROOT_STEPS = MAG_W / 2;
    localparam int CNT_W      = $clog2(ROOT_STEPS + 1);
    localparam logic [ROOT_W-1:0] DIV3_RECIP = 12'd2731;
    localparam int DIV3_SHIFT = 13;

    localparam logic REG_HEIGHT = 1'b0;
    localparam logic REG_WIDTH  = 1'b1;

    typedef struct packed {
        logic       accept;
        logic       load;
        logic       pick;
        logic [1:0] sel;
        logic       last;
        logic       square;
        logic       add;
        logic       root_step;
        logic       div;
        logic       update;
    } t_cmd;

    typedef struct packed {
        logic [3:0] mask;
    } t_status;

endpackage

@@ design/prewitt_edge_magnitude.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prewitt_edge_magnitude
// 3x3 prewitt gradient magnitude over channel sums of a raster pixel stream
// ----------------------------------------------------------------------------
// each taken pixel is loaded, then each of its 0..4 results is picked, squared, summed,
// rooted in the shared 12 step square root unit, divided by three, held while stalled;
// a new pixel is taken only after the last result and the line buffer update
// reset: synchronous active low, sizes return to 1024, position to row 0 col 0
// line buffers hold no reset value and need no clearing pass
module prewitt_edge_magnitude
    import pem_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_red_in,
    input  logic [7:0]        i_green_in,
    input  logic [7:0]        i_blue_in,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_edge_value,
    output logic [9:0]        o_out_row,
    output logic [9:0]        o_out_col,
    output logic              o_last_of_run
);
    t_cmd    cmd;
    t_status status;

    pem_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .o_cmd    (cmd)
    );

    pem_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_edge_value  (o_edge_value),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last_of_run (o_last_of_run)
    );
endmodule

@@ design/pem_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pem_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module pem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/pem_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pem_ctrl
// sequencer: request intake, result selection, root iterations, delivery
// ----------------------------------------------------------------------------
module pem_ctrl
    import pem_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output logic    o_stall,
    output logic    o_valid,
    output t_cmd    o_cmd
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LOAD = 9'b000000010,
        S_PICK = 9'b000000100,
        S_SQ   = 9'b000001000,
        S_ADD  = 9'b000010000,
        S_ROOT = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_OUT  = 9'b010000000,
        S_UPD  = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    logic [3:0]       r_mask, n_mask;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       sel;
    logic [3:0]       rest;

    always_comb begin
        if (r_mask[0]) begin
            sel = 2'd0;
        end else if (r_mask[1]) begin
            sel = 2'd1;
        end else if (r_mask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        rest = r_mask & ~(4'b0001 << sel);
    end

    always_comb begin
        n_state = r_state;
        n_mask  = r_mask;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.sel  = sel;
        o_cmd.last = (rest == 4'd0);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_mask = i_status.mask;
                n_state = S_PICK;
            end
            S_PICK: begin
                if (r_mask == 4'd0) begin
                    n_state = S_UPD;
                end else begin
                    o_cmd.pick = 1'b1;
                    n_mask = rest;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_cnt = '0;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_PICK;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mask  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
            r_cnt   <= n_cnt;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
endmodule

@@ design/pem_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pem_dp
// datapath: size registers, counters, line buffers, window, gradient math
// ----------------------------------------------------------------------------
module pem_dp
    import pem_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic [7:0]        i_red_in,
    input  logic [7:0]        i_green_in,
    input  logic [7:0]        i_blue_in,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic [7:0]        o_edge_value,
    output logic [9:0]        o_out_row,
    output logic [9:0]        o_out_col,
    output logic              o_last_of_run
);
    logic [SIZE_W-1:0] r_height, r_width;
    logic [SIZE_W-1:0] r_row, r_col;
    logic [ADDR_W-1:0] r_rr, r_cc;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_win [3][2];
    logic [SUM_W-1:0]  r_colv [3];
    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic [MAG_W-2:0]  r_sqx, r_sqy;
    logic [MAG_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+2:0] r_rem;
    logic [7:0]        r_edge;
    logic [9:0]        r_orow, r_ocol;
    logic              r_last;

    logic [SIZE_W-1:0] w, h, adj_row, adj_col, c_inc, r_inc;
    logic [ADDR_W-1:0] ram_addr;
    logic [SUM_W-1:0]  up_q, mid_q;
    logic signed [GRAD_W-1:0] g [4][4];
    logic signed [GRAD_W-1:0] gx, gy;
    logic [ROOT_W+2:0] rem_sh, trial;
    logic [2*ROOT_W-1:0] prod;

    always_comb begin
        w = (r_width == '0) ? SIZE_W'(1)
          : (r_width > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : r_width;
        h = (r_height == '0) ? SIZE_W'(1)
          : (r_height > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : r_height;
        adj_col = r_col;
        adj_row = r_row;
        if (r_col >= w) begin
            adj_col = '0;
            adj_row = r_row + 1'b1;
        end
        if (adj_row >= h) begin
            adj_row = '0;
        end
        c_inc = {1'b0, r_cc} + 1'b1;
        r_inc = {1'b0, r_rr} + 1'b1;
        ram_addr = i_cmd.update ? r_cc : adj_col[ADDR_W-1:0];
    end

    pem_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_addr  (ram_addr),
        .i_wdata (r_colv[1]),
        .o_rdata (up_q)
    );

    pem_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_addr  (ram_addr),
        .i_wdata (r_sum),
        .o_rdata (mid_q)
    );

    always_comb begin
        o_status.mask[0] = (r_rr >= 1) && (r_cc >= 1);
        o_status.mask[1] = (r_rr >= 1) && ({1'b0, r_cc} == w - 1'b1);
        o_status.mask[2] = ({1'b0, r_rr} == h - 1'b1) && (r_cc >= 1);
        o_status.mask[3] = ({1'b0, r_rr} == h - 1'b1) && ({1'b0, r_cc} == w - 1'b1);
    end

    // window grid with zero border row and column
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                g[r][c] = '0;
            end
        end
        for (int r = 0; r < 3; r++) begin
            g[r][0] = GRAD_W'(r_win[r][0]);
            g[r][1] = GRAD_W'(r_win[r][1]);
            g[r][2] = GRAD_W'(r_colv[r]);
        end
        gx = '0;
        gy = '0;
        for (int i = 0; i < 3; i++) begin
            gx = gx + g[i_cmd.sel[1] + 2][i_cmd.sel[0] + i] - g[i_cmd.sel[1]][i_cmd.sel[0] + i];
            gy = gy + g[i_cmd.sel[1] + i][i_cmd.sel[0]] - g[i_cmd.sel[1] + i][i_cmd.sel[0] + 2];
        end
        rem_sh = {r_rem[ROOT_W:0], r_rad[MAG_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        prod   = r_root * DIV3_RECIP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= SIZE_W'(MAX_HEIGHT);
            r_width  <= SIZE_W'(MAX_WIDTH);
            r_row    <= '0;
            r_col    <= '0;
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= '0;
                r_win[r][1] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_HEIGHT: r_height <= i_cfg_data;
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept && adj_col == '0) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= '0;
                    r_win[r][1] <= '0;
                end
            end
            if (i_cmd.update) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_colv[r];
                end
                if (c_inc == w) begin
                    r_col <= '0;
                    r_row <= (r_inc == h) ? '0 : r_inc;
                end else begin
                    r_col <= c_inc;
                    r_row <= {1'b0, r_rr};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rr  <= adj_row[ADDR_W-1:0];
            r_cc  <= adj_col[ADDR_W-1:0];
            r_sum <= SUM_W'(i_red_in) + SUM_W'(i_green_in) + SUM_W'(i_blue_in);
        end
        if (i_cmd.load) begin
            r_colv[0] <= (r_rr >= 2) ? up_q : '0;
            r_colv[1] <= (r_rr >= 1) ? mid_q : '0;
            r_colv[2] <= r_sum;
        end
        if (i_cmd.pick) begin
            r_gx   <= gx;
            r_gy   <= gy;
            r_orow <= r_rr - 10'd1 + 10'(i_cmd.sel[1]);
            r_ocol <= r_cc - 10'd1 + 10'(i_cmd.sel[0]);
            r_last <= i_cmd.last;
        end
        if (i_cmd.square) begin
            r_sqx <= (MAG_W-1)'(r_gx * r_gx);
            r_sqy <= (MAG_W-1)'(r_gy * r_gy);
        end
        if (i_cmd.add) begin
            r_rad  <= MAG_W'(r_sqx) + MAG_W'(r_sqy);
            r_root <= '0;
            r_rem  <= '0;
        end
        if (i_cmd.root_step) begin
            r_rad <= {r_rad[MAG_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div) begin
            r_edge <= (prod[2*ROOT_W-1:DIV3_SHIFT] > 'd255) ? 8'd255
                    : prod[DIV3_SHIFT +: 8];
        end
    end

    assign o_edge_value  = r_edge;
    assign o_out_row     = r_orow;
    assign o_out_col     = r_ocol;
    assign o_last_of_run = r_last;
endmodule
